FILE: hdl/uart_echo_pkg.sv
// ----------------------------------------------------------------------------
// uart_echo_pkg
// shared constants and types of the 8n1 echo transceiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uart_echo_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int QLEVEL_W   = 5;

  localparam logic [CFG_W-1:0] BIT_PERIOD_RST  = 16'h0901;
  localparam logic [CFG_W-1:0] START_DELAY_RST = 16'h0B00;

  localparam logic [3:0] TX_WAIT_PHASE  = 4'd15;
  localparam logic [3:0] TX_STOP_PHASE  = 4'd9;
  localparam logic [3:0] RX_FIRST_PHASE = 4'd10;
  localparam logic [3:0] RX_STOP_PHASE  = 4'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_PERIOD  = 1'b0,
    REG_START_DELAY = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PUSH = 1'b1
  } op_t;

  typedef struct packed {
    logic                tx_line;
    logic                rx_valid;
    logic [7:0]          rx_byte;
    logic                frame_error;
    logic                tx_active;
    logic [QLEVEL_W-1:0] queue_level;
    logic                push_dropped;
  } res_t;

endpackage

FILE: hdl/uart_8n1_echo_transceiver_unit.sv
// ----------------------------------------------------------------------------
// uart_8n1_echo_transceiver_unit
// each result goes into the output register, or first into the skid stage if held
// throughput: one input transaction per cycle, sustained while out_stall is low
// the fifo ram read on a byte load is registered before the tx shift register
// reset: synchronous active-low rst_n clears control state, config to defaults
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_8n1_echo_transceiver_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [uart_echo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uart_echo_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [7:0]                         in_tx_byte,
  input  logic                               in_rx_level,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_tx_line,
  output logic                               out_rx_valid,
  output logic [7:0]                         out_rx_byte,
  output logic                               out_frame_error,
  output logic                               out_tx_active,
  output logic [uart_echo_pkg::QLEVEL_W-1:0]  out_queue_level,
  output logic                               out_push_dropped
);
  import uart_echo_pkg::*;

  logic acc;
  res_t res, res_q;

  assign acc = in_valid && !in_stall;

  uart_echo_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .acc      (acc),
    .op       (in_op),
    .tx_byte  (in_tx_byte),
    .rx_level (in_rx_level),
    .res      (res)
  );

  uart_echo_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (acc),
    .din      (res),
    .full     (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dout     (res_q)
  );

  assign out_tx_line      = res_q.tx_line;
  assign out_rx_valid     = res_q.rx_valid;
  assign out_rx_byte      = res_q.rx_byte;
  assign out_frame_error  = res_q.frame_error;
  assign out_tx_active    = res_q.tx_active;
  assign out_queue_level  = res_q.queue_level;
  assign out_push_dropped = res_q.push_dropped;

endmodule

FILE: hdl/uart_echo_ram.sv
// ----------------------------------------------------------------------------
// uart_echo_ram
// generic single-write, single-read ram with registered read (read-first)
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_echo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/uart_echo_core.sv
// ----------------------------------------------------------------------------
// uart_echo_core
// config registers, transmit fifo around the ram, bit timers, tx and rx
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_echo_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [uart_echo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uart_echo_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                               acc,
  input  logic                               op,
  input  logic [7:0]                         tx_byte,
  input  logic                               rx_level,
  output uart_echo_pkg::res_t                res
);
  import uart_echo_pkg::*;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  logic [CFG_W-1:0]  bit_period_r, start_delay_r;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt, wptr_r, wptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        tx_shift_r, tx_shift_nxt, shift_cur;
  logic [3:0]        tx_phase_r, tx_phase_nxt;
  logic              tx_en_r, tx_en_nxt;
  logic [15:0]       tx_timer_r, tx_timer_nxt;
  logic              tx_level_r, tx_level_nxt;
  logic [7:0]        rx_shift_r, rx_shift_nxt;
  logic [3:0]        rx_phase_r, rx_phase_nxt;
  logic [15:0]       rx_timer_r, rx_timer_nxt;
  logic              rx_last_r, rx_last_nxt;
  logic              load_pend_r, load_pend_nxt;

  logic [16:0]       tx_t1, rx_t1;
  logic [15:0]       rx_per;
  logic              push_req, dropped, valid, ferr;
  logic [7:0]        push_data, rbyte;

  logic              ram_we, ram_re;
  logic [7:0]        ram_rdata;

  uart_echo_ram #(
    .WIDTH(8),
    .DEPTH(FIFO_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wptr_r),
    .wdata(push_data),
    .re   (ram_re),
    .raddr(rptr_r),
    .rdata(ram_rdata)
  );

  assign shift_cur = load_pend_r ? ram_rdata : tx_shift_r;
  assign tx_t1     = {1'b0, tx_timer_r} + 17'd1;
  assign rx_t1     = {1'b0, rx_timer_r} + 17'd1;
  assign rx_per    = (rx_phase_r == RX_FIRST_PHASE) ? start_delay_r : bit_period_r;

  always_comb begin
    rptr_nxt      = rptr_r;
    wptr_nxt      = wptr_r;
    fill_nxt      = fill_r;
    tx_shift_nxt  = shift_cur;
    tx_phase_nxt  = tx_phase_r;
    tx_en_nxt     = tx_en_r;
    tx_timer_nxt  = tx_timer_r;
    tx_level_nxt  = tx_level_r;
    rx_shift_nxt  = rx_shift_r;
    rx_phase_nxt  = rx_phase_r;
    rx_timer_nxt  = rx_timer_r;
    rx_last_nxt   = rx_last_r;
    load_pend_nxt = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    push_req      = 1'b0;
    push_data     = tx_byte;
    dropped       = 1'b0;
    valid         = 1'b0;
    ferr          = 1'b0;
    rbyte         = '0;
    if (acc) begin
      if (op == OP_PUSH) begin
        push_req = 1'b1;
      end else begin
        if (tx_en_r) begin
          if (tx_t1 >= {1'b0, bit_period_r}) begin
            tx_timer_nxt = '0;
            priority if (tx_phase_r > TX_STOP_PHASE) begin
              tx_phase_nxt = 4'd0;
              if (fill_r != '0) begin
                ram_re        = 1'b1;
                load_pend_nxt = 1'b1;
                rptr_nxt      = ptr_inc(rptr_r);
                fill_nxt      = fill_r - 1'b1;
              end
            end else if (tx_phase_r == 4'd0) begin
              tx_level_nxt = 1'b0;
              tx_phase_nxt = 4'd1;
            end else if (tx_phase_r < TX_STOP_PHASE) begin
              tx_level_nxt = shift_cur[0];
              tx_shift_nxt = {1'b0, shift_cur[7:1]};
              tx_phase_nxt = tx_phase_r + 4'd1;
            end else begin
              tx_phase_nxt = TX_WAIT_PHASE;
              tx_level_nxt = 1'b1;
              if (fill_r == '0) begin
                tx_en_nxt = 1'b0;
              end
            end
          end else begin
            tx_timer_nxt = tx_t1[15:0];
          end
        end
        if (rx_phase_r == 4'd0) begin
          if (rx_last_r && !rx_level) begin
            rx_phase_nxt = RX_FIRST_PHASE;
            rx_timer_nxt = '0;
          end
        end else if (rx_t1 >= {1'b0, rx_per}) begin
          rx_timer_nxt = '0;
          priority if (rx_phase_r > RX_STOP_PHASE) begin
            rx_shift_nxt = {rx_level, rx_shift_r[7:1]};
          end else if (rx_phase_r == RX_STOP_PHASE) begin
            ferr = !rx_level;
          end else begin
            valid        = 1'b1;
            rbyte        = rx_shift_r;
            push_req     = 1'b1;
            push_data    = rx_shift_r;
            rx_shift_nxt = '0;
          end
          rx_phase_nxt = rx_phase_r - 4'd1;
        end else begin
          rx_timer_nxt = rx_t1[15:0];
        end
        rx_last_nxt = rx_level;
      end
      if (push_req) begin
        if (fill_nxt >= FILL_W'(FIFO_DEPTH)) begin
          dropped = 1'b1;
        end else begin
          ram_we   = 1'b1;
          wptr_nxt = ptr_inc(wptr_r);
          fill_nxt = fill_nxt + 1'b1;
          if (!tx_en_nxt) begin
            tx_en_nxt    = 1'b1;
            tx_timer_nxt = '0;
          end
        end
      end
    end
  end

  always_comb begin
    res.tx_line      = tx_level_nxt;
    res.rx_valid     = valid;
    res.rx_byte      = rbyte;
    res.frame_error  = ferr;
    res.tx_active    = tx_en_nxt;
    res.queue_level  = QLEVEL_W'(fill_nxt);
    res.push_dropped = dropped;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r  <= BIT_PERIOD_RST;
      start_delay_r <= START_DELAY_RST;
      rptr_r        <= '0;
      wptr_r        <= '0;
      fill_r        <= '0;
      tx_shift_r    <= '0;
      tx_phase_r    <= TX_WAIT_PHASE;
      tx_en_r       <= 1'b0;
      tx_timer_r    <= '0;
      tx_level_r    <= 1'b1;
      rx_shift_r    <= '0;
      rx_phase_r    <= '0;
      rx_timer_r    <= '0;
      rx_last_r     <= 1'b1;
      load_pend_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_BIT_PERIOD:  bit_period_r  <= cfg_wdata;
          REG_START_DELAY: start_delay_r <= cfg_wdata;
          default: ;
        endcase
      end
      rptr_r      <= rptr_nxt;
      wptr_r      <= wptr_nxt;
      fill_r      <= fill_nxt;
      tx_shift_r  <= tx_shift_nxt;
      tx_phase_r  <= tx_phase_nxt;
      tx_en_r     <= tx_en_nxt;
      tx_timer_r  <= tx_timer_nxt;
      tx_level_r  <= tx_level_nxt;
      rx_shift_r  <= rx_shift_nxt;
      rx_phase_r  <= rx_phase_nxt;
      rx_timer_r  <= rx_timer_nxt;
      rx_last_r   <= rx_last_nxt;
      load_pend_r <= load_pend_nxt;
    end
  end

endmodule

FILE: hdl/uart_echo_outq.sv
// ----------------------------------------------------------------------------
// uart_echo_outq
// output register with skid stage for result transactions
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_echo_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  uart_echo_pkg::res_t din,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output uart_echo_pkg::res_t dout
);
  import uart_echo_pkg::*;

  logic main_v_r, main_v_nxt, skid_v_r, skid_v_nxt;
  logic main_free, load_main, load_skid;
  res_t main_r, skid_r;

  assign main_free = !main_v_r || !out_stall;
  assign load_main = main_free && (skid_v_r || push);
  assign load_skid = !main_free && push;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    if (main_free) begin
      main_v_nxt = skid_v_r || push;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_main) begin
      main_r <= skid_v_r ? skid_r : din;
    end
    if (load_skid) begin
      skid_r <= din;
    end
  end

  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign dout      = main_r;

endmodule

FILE: hdl/uart_echo_chk.sv
// ----------------------------------------------------------------------------
// uart_echo_chk
// port-level checks on result transactions, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_echo_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_tx_line,
  input logic                              out_rx_valid,
  input logic [7:0]                        out_rx_byte,
  input logic                              out_frame_error,
  input logic                              out_tx_active,
  input logic [uart_echo_pkg::QLEVEL_W-1:0] out_queue_level,
  input logic                              out_push_dropped
);
  import uart_echo_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rx_byte) && $stable(out_queue_level)
      && $stable(out_tx_line) && $stable(out_push_dropped))
    else $error("stalled result changed");

  a_ferr_not_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_error |-> !out_rx_valid)
    else $error("frame error and byte completion in one step");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rx_valid |-> out_rx_byte == 8'd0)
    else $error("rx byte nonzero without rx valid");

  a_queue_active: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_queue_level != '0 |-> out_tx_active)
    else $error("queued bytes with transmitter stopped");

  a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_active |-> out_tx_line)
    else $error("tx line low while transmitter stopped");

endmodule

bind uart_8n1_echo_transceiver_unit uart_echo_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_tx_line     (out_tx_line),
  .out_rx_valid    (out_rx_valid),
  .out_rx_byte     (out_rx_byte),
  .out_frame_error (out_frame_error),
  .out_tx_active   (out_tx_active),
  .out_queue_level (out_queue_level),
  .out_push_dropped(out_push_dropped)
);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 8n1 echo transceiver: random uart frames, noise
// and transmit pushes over several bit timings, each result transaction
// compared against an in-bench prediction of the line, fifo and receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import uart_echo_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    op_t        op;
    logic [7:0] tx_byte;
    logic       rx_level;
  } uart_item_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_BIT_PERIOD;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_op = 1'b0;
  logic [7:0]           in_tx_byte = 8'd0;
  logic                 in_rx_level = 1'b1;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_tx_line;
  logic                 out_rx_valid;
  logic [7:0]           out_rx_byte;
  logic                 out_frame_error;
  logic                 out_tx_active;
  logic [QLEVEL_W-1:0]  out_queue_level;
  logic                 out_push_dropped;

  uart_item_t pending_q[$];
  res_t       expected_q[$];
  uart_item_t next_item;
  res_t       want;
  int         push_pct = 0;
  bit         idle_on = 1'b1;
  int         send_gap = 0;
  int         hold_left = 0;
  int         error_count = 0;
  int         result_count = 0;
  int         cycle_count = 0;

  // predicted transceiver state
  logic [7:0]        tx_queue_mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  tx_queue_rd, tx_queue_wr;
  logic [FILL_W-1:0] tx_queue_fill;
  logic [7:0]        tx_bits;
  logic [3:0]        tx_step;
  logic              tx_running;
  logic [15:0]       tx_ticks;
  logic              tx_pin;
  logic [7:0]        rx_bits;
  logic [3:0]        rx_step;
  logic [15:0]       rx_ticks;
  logic              rx_prev;
  logic [15:0]       cfg_bit_ticks, cfg_first_ticks;

  uart_8n1_echo_transceiver_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_tx_byte       (in_tx_byte),
    .in_rx_level      (in_rx_level),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_tx_line      (out_tx_line),
    .out_rx_valid     (out_rx_valid),
    .out_rx_byte      (out_rx_byte),
    .out_frame_error  (out_frame_error),
    .out_tx_active    (out_tx_active),
    .out_queue_level  (out_queue_level),
    .out_push_dropped (out_push_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [16:0] tick_timer(logic [15:0] count, logic [15:0] period);
    if (int'(count) + 1 >= int'(period)) return {1'b1, 16'd0};
    return {1'b0, count + 16'd1};
  endfunction

  function automatic logic queue_byte(logic [7:0] data);
    if (tx_queue_fill >= FIFO_DEPTH) return 1'b1;
    tx_queue_mem[tx_queue_wr] = data;
    tx_queue_wr = tx_queue_wr + 1'b1;
    tx_queue_fill = tx_queue_fill + 1'b1;
    if (!tx_running) begin
      tx_running = 1'b1;
      tx_ticks = 16'd0;
    end
    return 1'b0;
  endfunction

  function automatic res_t predict_echo(op_t op, logic [7:0] data, logic level);
    res_t        r;
    logic [16:0] t;
    logic [15:0] period;
    r = '0;
    if (op == OP_PUSH) begin
      r.push_dropped = queue_byte(data);
    end else begin
      if (tx_running) begin
        t = tick_timer(tx_ticks, cfg_bit_ticks);
        tx_ticks = t[15:0];
        if (t[16]) begin
          if (tx_step > TX_STOP_PHASE) begin
            tx_step = 4'd0;
            if (tx_queue_fill != 0) begin
              tx_bits = tx_queue_mem[tx_queue_rd];
              tx_queue_rd = tx_queue_rd + 1'b1;
              tx_queue_fill = tx_queue_fill - 1'b1;
            end
          end else if (tx_step == 4'd0) begin
            tx_pin = 1'b0;
            tx_step = 4'd1;
          end else if (tx_step < TX_STOP_PHASE) begin
            tx_pin = tx_bits[0];
            tx_bits = tx_bits >> 1;
            tx_step = tx_step + 4'd1;
          end else begin
            tx_step = TX_WAIT_PHASE;
            tx_pin = 1'b1;
            if (tx_queue_fill == 0) tx_running = 1'b0;
          end
        end
      end
      if (rx_step == 4'd0) begin
        if (rx_prev && !level) begin
          rx_step = RX_FIRST_PHASE;
          rx_ticks = 16'd0;
        end
      end else begin
        period = (rx_step == RX_FIRST_PHASE) ? cfg_first_ticks : cfg_bit_ticks;
        t = tick_timer(rx_ticks, period);
        rx_ticks = t[15:0];
        if (t[16]) begin
          if (rx_step > RX_STOP_PHASE) begin
            rx_bits = {level, rx_bits[7:1]};
          end else if (rx_step == RX_STOP_PHASE) begin
            r.frame_error = !level;
          end else begin
            r.rx_valid = 1'b1;
            r.rx_byte = rx_bits;
            r.push_dropped = queue_byte(rx_bits);
            rx_bits = 8'd0;
          end
          rx_step = rx_step - 4'd1;
        end
      end
      rx_prev = level;
    end
    r.tx_line = tx_pin;
    r.tx_active = tx_running;
    r.queue_level = tx_queue_fill[QLEVEL_W-1:0];
    return r;
  endfunction

  task automatic report_error(string msg);
    if (error_count < PRINT_LIMIT) $display("ERROR: cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] exp_val);
    if (got !== exp_val)
      report_error($sformatf("result %0d %s got %0h want %0h", result_count, name, got, exp_val));
  endtask

  task automatic add_push(logic [7:0] data);
    uart_item_t it;
    it.op = OP_PUSH;
    it.tx_byte = data;
    it.rx_level = 1'($urandom_range(1));
    pending_q.push_back(it);
  endtask

  task automatic add_tick(logic level);
    uart_item_t it;
    if ($urandom_range(99) < push_pct) add_push(8'($urandom_range(255)));
    it.op = OP_TICK;
    it.tx_byte = 8'($urandom_range(255));
    it.rx_level = level;
    pending_q.push_back(it);
  endtask

  // line waveform of one frame, each bit held a full bit time
  task automatic add_frame(logic [7:0] data, logic stop, int idle);
    int p;
    int j;
    p = (cfg_bit_ticks == 0) ? 1 : cfg_bit_ticks;
    for (int k = 0; k < 10 * p; k++) begin
      j = k / p;
      add_tick(j == 0 ? 1'b0 : (j == 9 ? stop : data[j - 1]));
    end
    repeat (idle) add_tick(1'b1);
  endtask

  task automatic set_timing(logic [15:0] bit_ticks, logic [15:0] first_ticks);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_BIT_PERIOD;
    cfg_wdata <= bit_ticks;
    cfg_bit_ticks = bit_ticks;
    @(posedge clk);
    cfg_index <= REG_START_DELAY;
    cfg_wdata <= first_ticks;
    cfg_first_ticks = first_ticks;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_until_settled();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(predict_echo(op_t'(in_op), in_tx_byte, in_rx_level));
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (idle_on && $urandom_range(9) == 0) begin
          in_valid <= 1'b0;
          send_gap <= $urandom_range(4);
        end else if (pending_q.size() != 0) begin
          next_item = pending_q.pop_front();
          in_valid <= 1'b1;
          in_op <= next_item.op;
          in_tx_byte <= next_item.tx_byte;
          in_rx_level <= next_item.rx_level;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_error($sformatf("result transaction with nothing expected, queue_level %0d",
                                 out_queue_level));
        end else begin
          want = expected_q.pop_front();
          check_field("tx_line", 8'(out_tx_line), 8'(want.tx_line));
          check_field("rx_valid", 8'(out_rx_valid), 8'(want.rx_valid));
          check_field("rx_byte", out_rx_byte, want.rx_byte);
          check_field("frame_error", 8'(out_frame_error), 8'(want.frame_error));
          check_field("tx_active", 8'(out_tx_active), 8'(want.tx_active));
          check_field("queue_level", 8'(out_queue_level), 8'(want.queue_level));
          check_field("push_dropped", 8'(out_push_dropped), 8'(want.push_dropped));
        end
        result_count++;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (idle_on && $urandom_range(9) == 0) begin
        out_stall <= 1'b1;
        hold_left <= $urandom_range(4);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int p;
    int d;
    int target;
    tx_queue_rd = '0;
    tx_queue_wr = '0;
    tx_queue_fill = '0;
    tx_bits = 8'd0;
    tx_step = TX_WAIT_PHASE;
    tx_running = 1'b0;
    tx_ticks = 16'd0;
    tx_pin = 1'b1;
    rx_bits = 8'd0;
    rx_step = 4'd0;
    rx_ticks = 16'd0;
    rx_prev = 1'b1;
    cfg_bit_ticks = BIT_PERIOD_RST;
    cfg_first_ticks = START_DELAY_RST;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset timing: one push starts the transmitter, one tick
    add_push(8'hFF);
    add_tick(1'b1);
    wait_until_settled();

    // zero periods act as one tick; fill the fifo past full, then a bad stop bit
    set_timing(16'd0, 16'd0);
    add_push(8'h00);
    add_push(8'hFF);
    add_push(8'h01);
    add_push(8'h80);
    repeat (13) add_push(8'($urandom_range(255)));
    add_frame(8'hC3, 1'b0, 1);
    add_push(8'h3C);
    wait_until_settled();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_timing(16'd1, 16'd1);
        1: set_timing(16'd2, 16'd3);
        2: set_timing(16'd3, 16'd4);
        3: set_timing(16'hFFFF, 16'hFFFF);
        4: set_timing(16'd4, 16'd6);
        5: set_timing(16'd0, 16'd0);
        6: set_timing(16'd5, 16'd7);
        7: set_timing(16'd4, 16'd2);
        8: set_timing(16'($urandom_range(1, 8)), 16'($urandom_range(1, 16)));
        default: begin
          idle_on = 1'b0;
          set_timing(16'd3, 16'd4);
        end
      endcase
      p = (cfg_bit_ticks == 0) ? 1 : cfg_bit_ticks;
      d = (cfg_first_ticks == 0) ? 1 : cfg_first_ticks;
      target = (ph == 3) ? 40 : 135;
      while (pending_q.size() < target) begin
        push_pct = ($urandom_range(3) == 0) ? 30 : 2;
        case ($urandom_range(9))
          0: repeat ($urandom_range(1, 12)) add_tick(1'($urandom_range(1)));
          1: repeat ($urandom_range(1, 20)) add_push(8'($urandom_range(255)));
          2: begin
            // truncated frame followed by line noise
            add_tick(1'b0);
            repeat ($urandom_range(1, (p > 8) ? 64 : 8 * p)) add_tick(1'($urandom_range(1)));
          end
          default: begin
            if (p > 64 || d > 64) begin
              add_tick(1'($urandom_range(1)));
            end else begin
              add_frame(8'($urandom_range(255)), $urandom_range(7) != 0,
                        d + $urandom_range(2 * p));
            end
          end
        endcase
      end
      push_pct = 0;
      wait_until_settled();
    end

    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
